// ===== rtl/mnp_pkg.sv =====
package mnp_pkg;

    localparam int CHANNELS    = 16;
    localparam int NOTES       = 128;
    localparam int TIME_BITS   = 32;
    localparam int TABLE_DEPTH = NOTES * CHANNELS;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_NOTE_ON,
        KIND_NOTE_OFF,
        KIND_PROGRAM,
        KIND_SET_TEMPO,
        KIND_OTHER,
        KIND_TRACK_START,
        KIND_UNDEF6,
        KIND_UNDEF7
    } kind_t;

    typedef enum logic [2:0] {
        OP_TIME,
        OP_OPEN,
        OP_CLOSE,
        OP_PROGRAM,
        OP_TEMPO,
        OP_TRACK_START
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [27:0]      delta;
        logic [IDX_W-1:0] idx;
        logic [6:0]       note;
        logic [3:0]       chan;
        logic [6:0]       vel;
        logic [6:0]       prog;
        logic [23:0]      tempo;
    } cmd_t;

endpackage

// ===== rtl/mnp_ifs.sv =====
interface mnp_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [27:0] delta_ticks;
    logic        data_present;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [6:0]  program_req;
    logic [23:0] tempo_value;
    logic [7:0]  meta_length;

    modport source (
        output valid, kind, delta_ticks, data_present, note_number, velocity,
               channel, program_req, tempo_value, meta_length,
        input  ready
    );
    modport sink (
        input  valid, kind, delta_ticks, data_present, note_number, velocity,
               channel, program_req, tempo_value, meta_length,
        output ready
    );
endinterface

interface mnp_result_if;
    logic        valid;
    logic        ready;
    logic        note_valid;
    logic [6:0]  out_note;
    logic [3:0]  out_channel;
    logic [6:0]  out_velocity;
    logic [31:0] note_start;
    logic [31:0] note_length;
    logic [7:0]  out_track;
    logic [23:0] current_tempo;
    logic [6:0]  current_instrument;
    logic [31:0] max_end;

    modport source (
        output valid, note_valid, out_note, out_channel, out_velocity, note_start,
               note_length, out_track, current_tempo, current_instrument, max_end,
        input  ready
    );
    modport sink (
        input  valid, note_valid, out_note, out_channel, out_velocity, note_start,
               note_length, out_track, current_tempo, current_instrument, max_end,
        output ready
    );
endinterface

interface mnp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/midi_note_pairing_engine.sv =====
// MIDI note pairing engine.
// evt:   decoded track events, one transaction per event (valid/ready).
// pairs: one result transaction per event: closed note (if any), tempo,
//        instrument and running max note end.
// cfg:   write channel for track_number; always ready. Write only while idle.
// Accepted events go through a classifier into a two-entry queue; the
// execution side does a read-modify-write of the open-note table (2048
// entries, one read and one write port): the idle state pops an event and
// reads its entry, the execute state updates it and registers the result,
// and each event is finished before the next is popped. A track start
// event is followed by a table-clearing sweep before the next executes.
// Reset: tempo 500000, time, instrument, max_end and track_number 0; then a
// table sweep runs, during which up to two events are accepted and queued
// but not executed.
// A stalled pairs receiver holds the result; the queue keeps taking events
// until it is full, then evt.ready drops.
module midi_note_pairing_engine (
    input  logic          clk,
    input  logic          rst_n,
    mnp_event_if.sink     evt,
    mnp_result_if.source  pairs,
    mnp_cfg_if.sink       cfg
);
    import mnp_pkg::*;

    logic [7:0] track_reg;
    logic       push;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    cmd_t       push_cmd;
    cmd_t       head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= '0;
        end
        else if (cfg.valid)
        begin
            track_reg <= cfg.data;
        end
    end

    mnp_front u_front (
        .evt          (evt),
        .track_number (track_reg),
        .queue_full   (queue_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    mnp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mnp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head),
        .pop          (pop),
        .track_number (track_reg),
        .res          (pairs)
    );

endmodule

// ===== rtl/mnp_front.sv =====
module mnp_front (
    mnp_event_if.sink      evt,
    input  logic [7:0]     track_number,
    input  logic           queue_full,
    output logic           push,
    output mnp_pkg::cmd_t  cmd
);
    import mnp_pkg::*;

    localparam logic [7:0] TEMPO_META_LEN   = 8'd3;

    logic chan_ok;

    assign evt.ready = !queue_full;
    assign push      = evt.valid && !queue_full;
    assign chan_ok   = {1'b0, evt.channel} < 5'(CHANNELS);

    always_comb
    begin
        cmd.op    = OP_TIME;
        cmd.delta = evt.delta_ticks;
        cmd.idx   = IDX_W'(int'(evt.note_number) * CHANNELS + int'(evt.channel));
        cmd.note  = evt.note_number;
        cmd.chan  = evt.channel;
        cmd.vel   = evt.velocity;
        cmd.prog  = evt.program_req;
        cmd.tempo = evt.tempo_value;
        case (evt.kind)
            KIND_NOTE_ON, KIND_NOTE_OFF:
            begin
                if (chan_ok)
                begin
                    if (evt.kind == KIND_NOTE_ON && evt.data_present && evt.velocity != 7'd0)
                    begin
                        cmd.op = OP_OPEN;
                    end
                    else if (evt.kind == KIND_NOTE_OFF || evt.data_present)
                    begin
                        cmd.op = OP_CLOSE;
                    end
                end
            end
            KIND_PROGRAM:
            begin
                if (evt.data_present)
                begin
                    cmd.op = OP_PROGRAM;
                end
            end
            KIND_SET_TEMPO:
            begin
                if (track_number == 8'd0 && evt.meta_length == TEMPO_META_LEN)
                begin
                    cmd.op = OP_TEMPO;
                end
            end
            KIND_TRACK_START:
            begin
                cmd.op = OP_TRACK_START;
            end
            default:
            begin
                cmd.op = OP_TIME;
            end
        endcase
    end

endmodule

// ===== rtl/mnp_queue.sv =====
module mnp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mnp_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mnp_pkg::cmd_t  head
);
    import mnp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/mnp_back.sv =====
module mnp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  mnp_pkg::cmd_t  cmd,
    output logic           pop,
    input  logic [7:0]     track_number,
    mnp_result_if.source   res
);
    import mnp_pkg::*;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam int SUM_W   = ((TIME_BITS > 28) ? TIME_BITS : 28) + 1;
    localparam int START_W = 32;
    localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((65'd1 << TIME_BITS) - 65'd1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] start;
        logic [6:0]         vel;
    } entry_t;

    typedef struct packed {
        logic        note_valid;
        logic [6:0]  out_note;
        logic [3:0]  out_channel;
        logic [6:0]  out_velocity;
        logic [31:0] note_start;
        logic [31:0] note_length;
        logic [7:0]  out_track;
        logic [23:0] current_tempo;
        logic [6:0]  current_instrument;
        logic [31:0] max_end;
    } result_t;

    entry_t table_mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    cmd_t                 cur_reg, cur_next;
    logic [TIME_BITS-1:0] abs_reg, abs_next;
    logic [23:0]          tempo_reg, tempo_next;
    logic [6:0]           instr_reg, instr_next;
    logic [TIME_BITS-1:0] max_end_reg, max_end_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic [SUM_W-1:0]   abs_sum;
    logic [START_W-1:0] abs_trunc;
    logic               closing;

    assign abs_sum   = SUM_W'(abs_reg) + SUM_W'(cmd.delta);
    assign abs_trunc = START_W'(abs_reg);
    assign closing   = cur_reg.op == OP_CLOSE && rd_entry_reg.valid;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        abs_next       = abs_reg;
        tempo_next     = tempo_reg;
        instr_next     = instr_reg;
        max_end_next   = max_end_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg.idx;
        mem_wdata      = '0;

        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && (!res_valid_reg || res.ready))
                begin
                    pop        = 1'b1;
                    cur_next   = cmd;
                    state_next = S_EXEC;
                    if (cmd.op == OP_TRACK_START)
                    begin
                        abs_next   = '0;
                        instr_next = '0;
                    end
                    else
                    begin
                        abs_next = (abs_sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                        : abs_sum[TIME_BITS-1:0];
                    end
                    if (cmd.op == OP_PROGRAM)
                    begin
                        instr_next = cmd.prog;
                    end
                    if (cmd.op == OP_TEMPO)
                    begin
                        tempo_next = cmd.tempo;
                    end
                end
            end
            S_EXEC:
            begin
                if (cur_reg.op == OP_OPEN)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.start = abs_trunc;
                    mem_wdata.vel   = cur_reg.vel;
                end
                if (closing)
                begin
                    mem_we = 1'b1;
                    if (abs_reg > max_end_reg)
                    begin
                        max_end_next = abs_reg;
                    end
                end
                res_next.note_valid         = closing;
                res_next.out_note           = closing ? cur_reg.note : '0;
                res_next.out_channel        = closing ? cur_reg.chan : '0;
                res_next.out_velocity       = closing ? rd_entry_reg.vel : '0;
                res_next.note_start         = closing ? rd_entry_reg.start : '0;
                res_next.note_length        = closing ? abs_trunc - rd_entry_reg.start : '0;
                res_next.out_track          = track_number;
                res_next.current_tempo      = tempo_reg;
                res_next.current_instrument = instr_reg;
                res_next.max_end            = 32'(max_end_next);
                res_valid_next              = 1'b1;
                state_next = (cur_reg.op == OP_TRACK_START) ? S_CLEAR : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            abs_reg       <= '0;
            tempo_reg     <= TEMPO_DEFAULT;
            instr_reg     <= '0;
            max_end_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_reg       <= cur_next;
            abs_reg       <= abs_next;
            tempo_reg     <= tempo_next;
            instr_reg     <= instr_next;
            max_end_reg   <= max_end_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_entry_reg <= table_mem[cmd.idx];
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.note_valid         = res_reg.note_valid;
    assign res.out_note           = res_reg.out_note;
    assign res.out_channel        = res_reg.out_channel;
    assign res.out_velocity       = res_reg.out_velocity;
    assign res.note_start         = res_reg.note_start;
    assign res.note_length        = res_reg.note_length;
    assign res.out_track          = res_reg.out_track;
    assign res.current_tempo      = res_reg.current_tempo;
    assign res.current_instrument = res_reg.current_instrument;
    assign res.max_end            = res_reg.max_end;

    a_exec_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(pop))
        else $error("execute step without a popped transaction");

    a_slot_free_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> !res_valid_reg)
        else $error("result register busy while a transaction executes");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !pop)
        else $error("pop outside idle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_we)
        else $error("table write while idle");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && cur_reg.op != OP_TRACK_START |-> abs_reg >= $past(abs_reg))
        else $error("absolute time went backward");

endmodule

// ===== tb/tb_midi_note_pairing_engine.sv =====
`timescale 1ns / 1ps

module tb_midi_note_pairing_engine;
    import mnp_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [27:0] delta_ticks;
        logic        data_present;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [6:0]  program_req;
        logic [23:0] tempo_value;
        logic [7:0]  meta_length;
    } note_event_t;

    typedef struct packed {
        logic        note_valid;
        logic [6:0]  out_note;
        logic [3:0]  out_channel;
        logic [6:0]  out_velocity;
        logic [31:0] note_start;
        logic [31:0] note_length;
        logic [7:0]  out_track;
        logic [23:0] current_tempo;
        logic [6:0]  current_instrument;
        logic [31:0] max_end;
    } pair_result_t;

    localparam logic [7:0]  TEMPO_PAYLOAD_LEN  = 8'd3;
    localparam logic [23:0] TEMPO_RESET        = 24'd500000;
    localparam logic [27:0] DELTA_MAX          = 28'hFFFFFFF;
    localparam int          CYCLE_LIMIT        = 400000;
    localparam int          DRAIN_CYCLES       = 6;
    localparam int          RX_HOLD_CYCLES     = 300;
    localparam int          RANDOM_PHASE_ITEMS = 120;
    localparam int          KEY_POOL_SIZE      = 8;

    logic clk = 1'b0;
    logic rst_n;

    mnp_event_if  evt ();
    mnp_result_if pairs ();
    mnp_cfg_if    cfg ();

    midi_note_pairing_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .pairs (pairs),
        .cfg   (cfg)
    );

    always #2 clk = ~clk;

    // model state
    bit                   open_valid_m [TABLE_DEPTH];
    logic [31:0]          open_start_m [TABLE_DEPTH];
    logic [6:0]           open_vel_m   [TABLE_DEPTH];
    logic [TIME_BITS-1:0] tick_now     = '0;
    logic [23:0]          tempo_m      = TEMPO_RESET;
    logic [6:0]           instrument_m = '0;
    logic [31:0]          max_end_m    = '0;
    logic [7:0]           track_m      = '0;

    pair_result_t expected_pairs [$];
    logic [10:0]  key_pool [KEY_POOL_SIZE];

    int unsigned events_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned notes_paired    = 0;
    int unsigned track_writes    = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    bit tx_gaps_on    = 1'b1;
    int tx_burst_left = 0;

    logic [7:0] rx_mask       = 8'hFF;
    logic [2:0] rx_ptr        = '0;
    int         rx_phase_left = 0;
    logic       rx_hold       = 1'b0;
    logic       rx_ready      = 1'b0;
    event       rx_hold_go;

    assign pairs.ready = rx_ready;

    function automatic pair_result_t predict_pair(input note_event_t e);
        pair_result_t         r;
        logic [TIME_BITS:0]   sum;
        logic [IDX_W-1:0]     slot;
        r = '0;
        if (e.kind == KIND_TRACK_START)
        begin
            tick_now = '0;
            foreach (open_valid_m[i])
                open_valid_m[i] = 1'b0;
            instrument_m = '0;
        end
        else
        begin
            sum      = {1'b0, tick_now} + (TIME_BITS + 1)'(e.delta_ticks);
            tick_now = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
            if ((e.kind == KIND_NOTE_ON || e.kind == KIND_NOTE_OFF)
                && int'(e.channel) < CHANNELS)
            begin
                slot = IDX_W'(int'(e.note_number) * CHANNELS + int'(e.channel));
                if (e.kind == KIND_NOTE_ON && e.data_present && e.velocity != 7'd0)
                begin
                    open_valid_m[slot] = 1'b1;
                    open_start_m[slot] = tick_now[31:0];
                    open_vel_m[slot]   = e.velocity;
                end
                else if ((e.kind == KIND_NOTE_OFF || e.data_present) && open_valid_m[slot])
                begin
                    r.note_valid       = 1'b1;
                    r.out_note         = e.note_number;
                    r.out_channel      = e.channel;
                    r.out_velocity     = open_vel_m[slot];
                    r.note_start       = open_start_m[slot];
                    r.note_length      = tick_now[31:0] - open_start_m[slot];
                    open_valid_m[slot] = 1'b0;
                    if (tick_now > max_end_m)
                        max_end_m = tick_now[31:0];
                    notes_paired++;
                end
            end
            else if (e.kind == KIND_PROGRAM)
            begin
                if (e.data_present)
                    instrument_m = e.program_req;
            end
            else if (e.kind == KIND_SET_TEMPO)
            begin
                if (track_m == 8'd0 && e.meta_length == TEMPO_PAYLOAD_LEN)
                    tempo_m = e.tempo_value;
            end
        end
        r.out_track          = track_m;
        r.current_tempo      = tempo_m;
        r.current_instrument = instrument_m;
        r.max_end            = max_end_m;
        return r;
    endfunction

    function automatic logic [27:0] random_delta();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 28'($urandom_range(0, 255));
        else if (roll < 90)
            return 28'($urandom_range(0, 65535));
        else if (roll < 98)
            return 28'($urandom);
        return DELTA_MAX;
    endfunction

    function automatic note_event_t mk_event(input kind_t kind);
        note_event_t e;
        e.kind         = kind;
        e.delta_ticks  = random_delta();
        e.data_present = 1'($urandom);
        e.note_number  = 7'($urandom);
        e.velocity     = 7'($urandom);
        e.channel      = 4'($urandom);
        e.program_req  = 7'($urandom);
        e.tempo_value  = 24'($urandom);
        e.meta_length  = 8'($urandom);
        return e;
    endfunction

    function automatic note_event_t note_evt(input kind_t kind, input logic [27:0] delta,
                                             input logic data, input logic [6:0] note,
                                             input logic [6:0] vel, input logic [3:0] chan);
        note_event_t e;
        e              = mk_event(kind);
        e.delta_ticks  = delta;
        e.data_present = data;
        e.note_number  = note;
        e.velocity     = vel;
        e.channel      = chan;
        return e;
    endfunction

    function automatic note_event_t tempo_evt(input logic [7:0] len, input logic [23:0] value);
        note_event_t e;
        e             = mk_event(KIND_SET_TEMPO);
        e.meta_length = len;
        e.tempo_value = value;
        return e;
    endfunction

    function automatic note_event_t prog_evt(input logic data, input logic [6:0] prog);
        note_event_t e;
        e              = mk_event(KIND_PROGRAM);
        e.data_present = data;
        e.program_req  = prog;
        return e;
    endfunction

    function automatic void refill_keys();
        foreach (key_pool[i])
            key_pool[i] = 11'($urandom);
    endfunction

    // mostly note traffic on a small set of keys so that note-offs find open entries
    function automatic note_event_t gen_event(input bit allow_restart);
        note_event_t e;
        int unsigned roll;
        logic [10:0] key;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85)
            key = key_pool[3'($urandom_range(0, KEY_POOL_SIZE - 1))];
        else
            key = 11'($urandom);
        if (roll < 2)
            e = mk_event(allow_restart ? KIND_TRACK_START : KIND_OTHER);
        else if (roll < 30)
        begin
            e              = mk_event(KIND_NOTE_ON);
            e.data_present = 1'b1;
            e.velocity     = 7'($urandom_range(1, 127));
        end
        else if (roll < 52)
            e = mk_event(KIND_NOTE_OFF);
        else if (roll < 62)
        begin
            e              = mk_event(KIND_NOTE_ON);
            e.data_present = 1'b1;
            e.velocity     = '0;
        end
        else if (roll < 66)
        begin
            e              = mk_event(KIND_NOTE_ON);
            e.data_present = 1'b0;
        end
        else if (roll < 74)
        begin
            e              = mk_event(KIND_PROGRAM);
            e.data_present = ($urandom_range(0, 4) != 0);
        end
        else if (roll < 82)
        begin
            e = mk_event(KIND_SET_TEMPO);
            if ($urandom_range(0, 9) < 7)
                e.meta_length = TEMPO_PAYLOAD_LEN;
        end
        else if (roll < 92)
            e = mk_event(KIND_OTHER);
        else if (roll < 96)
            e = mk_event(kind_t'(3'($urandom_range(6, 7))));
        else
            e = mk_event(kind_t'(3'($urandom)));
        if (roll >= 2 && roll < 66)
            {e.note_number, e.channel} = key;
        if (e.kind == KIND_TRACK_START && !allow_restart)
            e.kind = KIND_OTHER;
        if (e.kind == KIND_TRACK_START)
            refill_keys();
        return e;
    endfunction

    task automatic send_event(input note_event_t e);
        pair_result_t want;
        if (tx_gaps_on && tx_burst_left == 0)
        begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            tx_burst_left = $urandom_range(1, 16);
        end
        evt.valid        <= 1'b1;
        evt.kind         <= e.kind;
        evt.delta_ticks  <= e.delta_ticks;
        evt.data_present <= e.data_present;
        evt.note_number  <= e.note_number;
        evt.velocity     <= e.velocity;
        evt.channel      <= e.channel;
        evt.program_req  <= e.program_req;
        evt.tempo_value  <= e.tempo_value;
        evt.meta_length  <= e.meta_length;
        do
            @(posedge clk);
        while (!evt.ready);
        want = predict_pair(e);
        expected_pairs.insert(expected_pairs.size(), want);
        events_sent++;
        if (tx_burst_left != 0)
            tx_burst_left--;
    endtask

    task automatic drain_pairs();
        evt.valid <= 1'b0;
        tx_burst_left = 0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_track(input logic [7:0] value);
        drain_pairs();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        track_m = value;
        track_writes++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        pair_result_t want;
        if (rst_n && pairs.valid && pairs.ready)
        begin
            if (expected_pairs.size() == 0)
                report_mismatch("result transaction with nothing pending");
            else
            begin
                want = expected_pairs.pop_front();
                check_field("note_valid", 32'(pairs.note_valid), 32'(want.note_valid));
                check_field("out_note", 32'(pairs.out_note), 32'(want.out_note));
                check_field("out_channel", 32'(pairs.out_channel), 32'(want.out_channel));
                check_field("out_velocity", 32'(pairs.out_velocity),
                            32'(want.out_velocity));
                check_field("note_start", pairs.note_start, want.note_start);
                check_field("note_length", pairs.note_length, want.note_length);
                check_field("out_track", 32'(pairs.out_track), 32'(want.out_track));
                check_field("current_tempo", 32'(pairs.current_tempo),
                            32'(want.current_tempo));
                check_field("current_instrument", 32'(pairs.current_instrument),
                            32'(want.current_instrument));
                check_field("max_end", pairs.max_end, want.max_end);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_phase_left <= $urandom_range(32, 256);
            case ($urandom_range(0, 3))
                0, 1:    rx_mask <= 8'hFF;
                2:       rx_mask <= 8'($urandom) | 8'h01;
                default: rx_mask <= 8'h21;
            endcase
        end
        else
        begin
            rx_phase_left <= rx_phase_left - 1;
        end
        rx_ptr   <= rx_ptr + 1'b1;
        rx_ready <= !rx_hold && rx_mask[rx_ptr];
    end

    always
    begin
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_pairs.size());
            $display("tb_midi_note_pairing_engine: done, errors");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_event(note_evt(KIND_OTHER, 28'd0, 1'b0, 7'd0, 7'd0, 4'd0));
        send_event(note_evt(KIND_NOTE_ON, 28'd5, 1'b1, 7'd0, 7'd127, 4'd0));
        send_event(note_evt(KIND_NOTE_ON, DELTA_MAX, 1'b1, 7'd127, 7'd1, 4'd15));
        send_event(note_evt(KIND_NOTE_OFF, 28'd10, 1'b1, 7'd0, 7'd0, 4'd0));
        // zero velocity note-on closes
        send_event(note_evt(KIND_NOTE_ON, 28'd3, 1'b1, 7'd127, 7'd0, 4'd15));
        send_event(note_evt(KIND_NOTE_OFF, 28'd1, 1'b1, 7'd5, 7'd9, 4'd3));
        send_event(note_evt(KIND_NOTE_ON, 28'd2, 1'b0, 7'd5, 7'd64, 4'd3));
        send_event(note_evt(KIND_NOTE_OFF, 28'd2, 1'b1, 7'd5, 7'd0, 4'd3));
        send_event(note_evt(KIND_NOTE_ON, 28'd4, 1'b1, 7'd60, 7'd100, 4'd9));
        send_event(note_evt(KIND_NOTE_ON, 28'd7, 1'b1, 7'd60, 7'd20, 4'd9));
        send_event(note_evt(KIND_NOTE_OFF, 28'd9, 1'b0, 7'd60, 7'd127, 4'd9));
        send_event(note_evt(KIND_NOTE_ON, 28'd1, 1'b1, 7'd70, 7'd90, 4'd4));
        send_event(note_evt(KIND_NOTE_ON, 28'd1, 1'b0, 7'd70, 7'd0, 4'd4));
        send_event(note_evt(KIND_NOTE_OFF, 28'd1, 1'b0, 7'd70, 7'd0, 4'd4));
        send_event(prog_evt(1'b1, 7'd127));
        send_event(prog_evt(1'b0, 7'd5));
        send_event(tempo_evt(TEMPO_PAYLOAD_LEN, 24'hFFFFFF));
        send_event(tempo_evt(8'd2, 24'd0));
        send_event(tempo_evt(TEMPO_PAYLOAD_LEN, 24'd0));
        send_event(note_evt(KIND_UNDEF6, 28'd100, 1'b1, 7'd1, 7'd1, 4'd1));
        send_event(note_evt(KIND_UNDEF7, 28'd100, 1'b1, 7'd1, 7'd1, 4'd1));
        send_event(note_evt(KIND_NOTE_ON, 28'd8, 1'b1, 7'd10, 7'd50, 4'd2));
        send_event(note_evt(KIND_TRACK_START, DELTA_MAX, 1'b1, 7'd10, 7'd50, 4'd2));
        send_event(note_evt(KIND_NOTE_OFF, 28'd0, 1'b1, 7'd10, 7'd50, 4'd2));
        write_track(8'd255);
        send_event(tempo_evt(TEMPO_PAYLOAD_LEN, 24'h123456));
        send_event(prog_evt(1'b1, 7'd0));
        write_track(8'd0);
        send_event(tempo_evt(TEMPO_PAYLOAD_LEN, TEMPO_RESET));
    endtask

    task automatic test_time_saturation();
        note_event_t e;
        send_event(mk_event(KIND_TRACK_START));
        send_event(note_evt(KIND_NOTE_ON, 28'd0, 1'b1, 7'd1, 7'd33, 4'd1));
        repeat (16)
        begin
            e             = mk_event(KIND_OTHER);
            e.delta_ticks = DELTA_MAX;
            send_event(e);
        end
        // lands exactly on the top tick, then sticks there
        send_event(note_evt(KIND_NOTE_ON, 28'd15, 1'b1, 7'd2, 7'd44, 4'd2));
        e             = mk_event(KIND_OTHER);
        e.delta_ticks = DELTA_MAX;
        send_event(e);
        send_event(note_evt(KIND_NOTE_OFF, 28'd1, 1'b1, 7'd1, 7'd0, 4'd1));
        send_event(note_evt(KIND_NOTE_ON, 28'd0, 1'b1, 7'd2, 7'd0, 4'd2));
        send_event(mk_event(KIND_TRACK_START));
    endtask

    task automatic test_input_backpressure();
        drain_pairs();
        tx_gaps_on = 1'b0;
        -> rx_hold_go;
        repeat (40) send_event(gen_event(1'b0));
        tx_gaps_on = 1'b1;
        drain_pairs();
    endtask

    task automatic test_random_traffic();
        logic [7:0] settings [6];
        settings = '{8'd255, 8'd1, 8'd0, 8'($urandom), 8'd128, 8'd0};
        foreach (settings[p])
        begin
            write_track(settings[p]);
            refill_keys();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (RANDOM_PHASE_ITEMS) send_event(gen_event(1'b1));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        evt.valid        = 1'b0;
        evt.kind         = '0;
        evt.delta_ticks  = '0;
        evt.data_present = 1'b0;
        evt.note_number  = '0;
        evt.velocity     = '0;
        evt.channel      = '0;
        evt.program_req  = '0;
        evt.tempo_value  = '0;
        evt.meta_length  = '0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        refill_keys();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_time_saturation();
        test_input_backpressure();
        test_random_traffic();
        drain_pairs();

        $display("tb_midi_note_pairing_engine: %0d events, %0d results checked, %0d paired",
                 events_sent, results_checked, notes_paired);
        $display("tb_midi_note_pairing_engine: %0d track writes, tick saturation, %0d-cycle hold",
                 track_writes, RX_HOLD_CYCLES);
        if (error_count == 0)
            $display("tb_midi_note_pairing_engine: done, clean");
        else
            $display("tb_midi_note_pairing_engine: done, errors");
        $finish;
    end

endmodule
